/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when a holds, b must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: label");

// when a holds, b must hold in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

/* src/amcs_pkg.sv */
// shared widths and inter-module types for the alpha modulation code search
package amcs_pkg;

    localparam int ColorW = 15;
    localparam int ChanW  = 5;
    localparam int CodeW  = 16;
    localparam int NibW   = 4;
    localparam int DiffW  = 10;
    localparam int SqW    = 16;
    localparam int SumW   = 18;
    localparam int WgtW   = 5;
    localparam int CostW  = 23;

    localparam logic [CodeW-1:0] LastCode = {CodeW{1'b1}};
    localparam logic [WgtW-1:0]  WgtBase  = WgtW'(4);

    // one candidate code entering the cost pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [CodeW-1:0] code;
    } cand_t;

    // one candidate leaving the cost pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [CodeW-1:0] code;
        logic [CostW-1:0] cost;
    } cand_cost_t;

    // search result status from the tracker
    typedef struct packed {
        logic             done;
        logic [CodeW-1:0] best_code;
    } trk_status_t;

endpackage

/* src/amcs_cost_unit.sv */
// four-stage pipelined cost evaluator, one candidate code per cycle
module amcs_cost_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [amcs_pkg::ColorW-1:0]    color,
    input  amcs_pkg::cand_t                cand_in,
    output amcs_pkg::cand_cost_t           cand_out
);

    // signed channel difference 8*c - m*ma - 128 + 8*ma
    function automatic logic signed [amcs_pkg::DiffW-1:0] chan_diff(
        input logic [amcs_pkg::ChanW-1:0] c,
        input logic [amcs_pkg::NibW-1:0]  m,
        input logic [amcs_pkg::NibW-1:0]  ma
    );
        logic [7:0]         prod;
        logic signed [11:0] t;
        prod = {4'b0000, m} * {4'b0000, ma};
        t = $signed({4'b0000, c, 3'b000}) - $signed({4'b0000, prod})
            - 12'sd128 + $signed({5'b00000, ma, 3'b000});
        return t[amcs_pkg::DiffW-1:0];
    endfunction

    amcs_pkg::cand_t tag1_reg, tag2_reg, tag3_reg;
    logic [amcs_pkg::NibW-1:0] ma1_reg, ma2_reg;
    logic [amcs_pkg::WgtW-1:0] wgt3_reg;
    logic signed [amcs_pkg::DiffW-1:0] dr_reg, dg_reg, db_reg;
    logic [amcs_pkg::SqW-1:0]  sr_reg, sg_reg, sb_reg;
    logic [amcs_pkg::SumW-1:0] sum_reg;
    amcs_pkg::cand_cost_t out_reg;

    logic signed [2*amcs_pkg::DiffW-1:0] pr, pg, pb;
    logic [amcs_pkg::SumW-1:0]  sum_next;
    logic [amcs_pkg::CostW-1:0] cost_next;

    // squares, sum and weighting
    always_comb begin
        pr = (2*amcs_pkg::DiffW)'(dr_reg) * (2*amcs_pkg::DiffW)'(dr_reg);
        pg = (2*amcs_pkg::DiffW)'(dg_reg) * (2*amcs_pkg::DiffW)'(dg_reg);
        pb = (2*amcs_pkg::DiffW)'(db_reg) * (2*amcs_pkg::DiffW)'(db_reg);
        sum_next = {2'b00, sr_reg} + {2'b00, sg_reg} + {2'b00, sb_reg};
        cost_next = amcs_pkg::CostW'(sum_reg) * amcs_pkg::CostW'(wgt3_reg);
    end

    // valid flags and payload of each stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
            out_reg.valid  <= 1'b0;
        end else begin
            tag1_reg.valid <= cand_in.valid;
            tag2_reg.valid <= tag1_reg.valid;
            tag3_reg.valid <= tag2_reg.valid;
            out_reg.valid  <= tag3_reg.valid;
        end
        // stage 1: channel differences
        tag1_reg.first <= cand_in.first;
        tag1_reg.last  <= cand_in.last;
        tag1_reg.code  <= cand_in.code;
        ma1_reg <= cand_in.code[3:0];
        dr_reg  <= chan_diff(color[14:10], cand_in.code[15:12], cand_in.code[3:0]);
        dg_reg  <= chan_diff(color[9:5],   cand_in.code[11:8],  cand_in.code[3:0]);
        db_reg  <= chan_diff(color[4:0],   cand_in.code[7:4],   cand_in.code[3:0]);
        // stage 2: squares
        tag2_reg.first <= tag1_reg.first;
        tag2_reg.last  <= tag1_reg.last;
        tag2_reg.code  <= tag1_reg.code;
        ma2_reg <= ma1_reg;
        sr_reg  <= pr[amcs_pkg::SqW-1:0];
        sg_reg  <= pg[amcs_pkg::SqW-1:0];
        sb_reg  <= pb[amcs_pkg::SqW-1:0];
        // stage 3: sum of squares and weight
        tag3_reg.first <= tag2_reg.first;
        tag3_reg.last  <= tag2_reg.last;
        tag3_reg.code  <= tag2_reg.code;
        sum_reg  <= sum_next;
        wgt3_reg <= amcs_pkg::WgtBase + {1'b0, ma2_reg};
        // stage 4: weighted cost
        out_reg.first <= tag3_reg.first;
        out_reg.last  <= tag3_reg.last;
        out_reg.code  <= tag3_reg.code;
        out_reg.cost  <= cost_next;
    end

    assign cand_out = out_reg;

endmodule

/* src/amcs_best_tracker.sv */
// running minimum of candidate costs, first strictly smaller cost wins
module amcs_best_tracker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  amcs_pkg::cand_cost_t   cand,
    output amcs_pkg::trk_status_t  status
);

    logic [amcs_pkg::CostW-1:0] best_cost_reg;
    logic [amcs_pkg::CodeW-1:0] best_code_reg;
    logic                       done_reg;
    logic                       take;

    assign take = cand.valid && (cand.first || (cand.cost < best_cost_reg));

    // done pulse after the last candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= cand.valid && cand.last;
        end
    end

    // best cost and code
    always_ff @(posedge aclk) begin
        if (take) begin
            best_cost_reg <= cand.cost;
            best_code_reg <= cand.code;
        end
    end

    assign status.done      = done_reg;
    assign status.best_code = best_code_reg;

endmodule

/* src/alpha_modulation_code_search_unit.sv */
// Alpha modulation code search: each input beat starts a search for the code of least cost.
// All 65536 codes pass the pipelined cost unit, one per cycle, then the pipeline drains into the tracker.
// One item at a time: a new beat is taken only after the previous search has passed on its result.
// The result waits in an output register while the next search runs; a search that
// ends before that result is taken holds, with the input blocked, until it is.
// Synchronous active-low reset clears the sequencer and the valid flags.
module alpha_modulation_code_search_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [amcs_pkg::ColorW-1:0]  s_color_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [amcs_pkg::CodeW-1:0]   m_best_code
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                       state_reg, state_next;
    logic [amcs_pkg::CodeW-1:0]   code_reg, code_next;
    logic [amcs_pkg::ColorW-1:0]  color_reg, color_next;
    logic                         m_valid_reg, m_valid_next;
    logic [amcs_pkg::CodeW-1:0]   m_best_code_reg, m_best_code_next;

    amcs_pkg::cand_t       cand;
    amcs_pkg::cand_cost_t  cand_cost;
    amcs_pkg::trk_status_t trk;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_ready;

    // candidate issue from the code counter
    assign cand.valid = (state_reg == ST_SCAN);
    assign cand.first = (code_reg == '0);
    assign cand.last  = (code_reg == amcs_pkg::LastCode);
    assign cand.code  = code_reg;

    amcs_cost_unit u_cost (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .color    (color_reg),
        .cand_in  (cand),
        .cand_out (cand_cost)
    );

    amcs_best_tracker u_trk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cand    (cand_cost),
        .status  (trk)
    );

    // sequencer next state
    always_comb begin
        state_next       = state_reg;
        code_next        = code_reg;
        color_next       = color_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_best_code_next = m_best_code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    color_next = s_color_index;
                    code_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                code_next = code_reg + amcs_pkg::CodeW'(1);
                if (cand.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (trk.done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_best_code_next = trk.best_code;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        code_reg        <= code_next;
        color_reg       <= color_next;
        m_best_code_reg <= m_best_code_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_best_code = m_best_code_reg;

endmodule

/* src/amcs_checker.sv */
// port-level checker for the code search unit, with its bind
`include "assert_macros.svh"

module amcs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [amcs_pkg::CodeW-1:0]   m_best_code
);

    // a search blocks further input beats
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // no result appears right after an input beat
    `ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

    // a result is only produced at the end of a search
    `ASSERT_IMPLIES(a_result_ends_search, aclk, aresetn, $rose(m_valid), !$past(s_ready))

    // a stalled result beat holds its value
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_best_code))

endmodule

bind alpha_modulation_code_search_unit amcs_checker u_amcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_best_code   (m_best_code)
);
